[rtl/chc_pkg.sv]
package chc_pkg;
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_OBJECT = 2'd2;
  localparam logic [1:0] REG_SAFE   = 2'd0;
  localparam logic [1:0] REG_SPEED  = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;
  localparam int CFG_W = 19;
  localparam logic [16:0] INV_GAIN = 17'd39797;
  localparam int VW = 40;
  typedef logic signed [VW-1:0] vec_t;
endpackage

[rtl/chc_cordic_cell.sv]
module chc_cordic_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  logic         step_i,
  input  logic [4:0]   shift_i,
  input  chc_pkg::vec_t vx_i,
  input  chc_pkg::vec_t vy_i,
  output chc_pkg::vec_t c_o,
  output chc_pkg::vec_t s_o
);
  import chc_pkg::*;
  vec_t vx_q, vy_q, c_q, s_q;
  vec_t vx_d, vy_d, c_d, s_d;

  always_comb begin
    vx_d = vx_q; vy_d = vy_q; c_d = c_q; s_d = s_q;
    if (load_i) begin
      vx_d = vx_i; vy_d = vy_i;
      c_d = vec_t'(INV_GAIN); s_d = '0;
    end else if (step_i) begin
      if (!vy_q[VW-1]) begin
        vx_d = vx_q + (vy_q >>> shift_i); vy_d = vy_q - (vx_q >>> shift_i);
        c_d = c_q - (s_q >>> shift_i);   s_d = s_q + (c_q >>> shift_i);
      end else begin
        vx_d = vx_q - (vy_q >>> shift_i); vy_d = vy_q + (vx_q >>> shift_i);
        c_d = c_q + (s_q >>> shift_i);   s_d = s_q - (c_q >>> shift_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= '0; vy_q <= '0; c_q <= '0; s_q <= '0;
    end else begin
      vx_q <= vx_d; vy_q <= vy_d; c_q <= c_d; s_q <= s_d;
    end
  end
  assign c_o = c_q;
  assign s_o = s_q;
endmodule

[rtl/chc_target_cell.sv]
module chc_target_cell (
  input  logic               clk_i,
  input  logic               write_i,
  input  logic               shift_i,
  input  logic signed [19:0] x_i,
  input  logic signed [19:0] y_i,
  output logic signed [19:0] x_o,
  output logic signed [19:0] y_o
);
  logic signed [19:0] x_q, y_q;
  always_ff @(posedge clk_i) begin
    if (write_i || shift_i) begin
      x_q <= x_i;
      y_q <= y_i;
    end
  end
  assign x_o = x_q;
  assign y_o = y_q;
endmodule

[rtl/collision_hazard_check.sv]
// Frame-based collision hazard check. Clear and append commands do not raise busy.
// An object runs its heading and prediction and, when the table holds any point,
// the target walk around the ring of target cells; busy is high until both are
// done. On the last object of a frame the flags appear for one cycle under
// valid_o, and the receiver cannot stall.
module collision_hazard_check #(
  parameter int MAX_TARGETS  = 32,
  parameter int CORDIC_ITERS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation_i,
  input  logic signed [19:0] pos_x_i,
  input  logic signed [19:0] pos_y_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] rel_speed_i,
  input  logic [7:0]         class_label_i,
  input  logic               last_object_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [chc_pkg::CFG_W-1:0] cfg_data_i,
  output logic               valid_o,
  output logic               hazard_o,
  output logic               speed_range_hit_o,
  output logic               proximity_hit_o,
  output logic               targets_dropped_o
);
  import chc_pkg::*;
  localparam int CW = $clog2(MAX_TARGETS + 1);
  localparam int SW = $clog2(CORDIC_ITERS + 8);
  localparam logic [SW-1:0] ST_LAST = SW'(CORDIC_ITERS + 6);

  logic [18:0] safe_q, radius_q;
  logic [14:0] minspd_q;
  logic [CW-1:0] cnt_q, walk_q;
  logic [SW-1:0] step_q;
  logic busy_q, spd_flag_q, near_flag_q, drop_flag_q, hd_done_q, walk_done_q;
  logic signed [19:0] px_q, py_q;
  logic signed [15:0] spd_q;
  logic lab_q, last_q, flip_q, lock_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
  logic signed [33:0] norm_q, m20_q, vx_q, vy_q;
  logic [37:0] r2_q, lim_q;
  logic signed [19:0] tx [MAX_TARGETS];
  logic signed [19:0] ty [MAX_TARGETS];
  vec_t c_w, s_w, hx_q, hy_q;
  logic signed [21:0] ex_q, ey_q;
  logic signed [43:0] ex2_q, ey2_q;
  logic accept, is_obj, append;

  assign accept = start && !busy_q;
  assign is_obj = accept && operation_i == OP_OBJECT;
  assign append = accept && operation_i == OP_APPEND && cnt_q < CW'(MAX_TARGETS);
  assign busy = busy_q;

  // Ring of target cells: new points enter at the tail; the walk rotates the ring.
  logic walking;
  assign walking = busy_q && !walk_done_q;
  for (genvar g = 0; g < MAX_TARGETS; g++) begin : g_cell
    logic wr;
    logic signed [19:0] xi, yi;
    assign wr = append && cnt_q == CW'(g);
    assign xi = wr ? pos_x_i : tx[(g + 1) % MAX_TARGETS];
    assign yi = wr ? pos_y_i : ty[(g + 1) % MAX_TARGETS];
    chc_target_cell u_cell (
      .clk_i, .write_i(wr), .shift_i(walking),
      .x_i(xi), .y_i(yi), .x_o(tx[g]), .y_o(ty[g])
    );
  end

  logic signed [20:0] dx, dy;
  logic [41:0] d2;
  assign dx = 21'(px_q) - 21'(tx[0]);
  assign dy = 21'(py_q) - 21'(ty[0]);
  assign d2 = 42'(dx * dx) + 42'(dy * dy);

  chc_cordic_cell u_cordic (
    .clk_i, .rst_ni,
    .load_i(busy_q && step_q == SW'(2)),
    .step_i(busy_q && step_q > SW'(2) && step_q <= SW'(CORDIC_ITERS + 2)),
    .shift_i(5'(step_q - SW'(3))),
    .vx_i(vec_t'(flip_q ? -vx_q : vx_q)), .vy_i(vec_t'(flip_q ? -vy_q : vy_q)),
    .c_o(c_w), .s_o(s_w)
  );

  logic signed [56:0] mx, my;
  assign mx = hx_q * spd_q + 57'sd32768;
  assign my = hy_q * spd_q + 57'sd32768;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= pos_x_i; py_q <= pos_y_i; spd_q <= rel_speed_i;
      qx_q <= quat_x_i; qy_q <= quat_y_i; qz_q <= quat_z_i; qw_q <= quat_w_i;
      lab_q <= class_label_i >= 8'd1 && class_label_i <= 8'd3;
      last_q <= last_object_i;
      r2_q <= 38'(radius_q * radius_q);
      lim_q <= 38'(safe_q * safe_q);
    end
    case (step_q)
      SW'(0): begin
        norm_q <= 34'(qx_q * qx_q) + 34'(qy_q * qy_q) + 34'(qz_q * qz_q) + 34'(qw_q * qw_q);
        m20_q <= 34'(qx_q * qz_q) - 34'(qw_q * qy_q);
        vx_q <= 34'(qw_q * qw_q) + 34'(qx_q * qx_q) - 34'(qy_q * qy_q) - 34'(qz_q * qz_q);
        vy_q <= 34'(qx_q * qy_q) + 34'(qw_q * qz_q);
      end
      SW'(1): begin
        m20_q <= m20_q[33] ? -(m20_q <<< 1) : (m20_q <<< 1);
        vy_q <= vy_q <<< 1;
        flip_q <= vx_q[33];
      end
      SW'(2): lock_q <= m20_q >= norm_q;
      SW'(CORDIC_ITERS + 3): begin
        hx_q <= lock_q ? vec_t'(65536) : (flip_q ? -c_w : c_w);
        hy_q <= lock_q ? '0 : (flip_q ? -s_w : s_w);
      end
      SW'(CORDIC_ITERS + 4): begin
        ex_q <= 22'(px_q) + 22'(mx >>> 16);
        ey_q <= 22'(py_q) + 22'(my >>> 16);
      end
      default: begin
        ex2_q <= ex_q * ex_q;
        ey2_q <= ey_q * ey_q;
      end
    endcase
  end

  logic spd_hit;
  assign spd_hit = lab_q && !spd_q[15] && spd_q >= $signed({1'b0, minspd_q})
                   && (ex2_q + ey2_q) <= 44'(lim_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safe_q <= 19'd5120; minspd_q <= 15'd1423; radius_q <= 19'd384;
      cnt_q <= '0; walk_q <= '0; step_q <= '0; busy_q <= 1'b0;
      spd_flag_q <= 1'b0; near_flag_q <= 1'b0; drop_flag_q <= 1'b0;
      hd_done_q <= 1'b0; walk_done_q <= 1'b0; valid_o <= 1'b0;
      hazard_o <= 1'b0; speed_range_hit_o <= 1'b0; proximity_hit_o <= 1'b0;
      targets_dropped_o <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SAFE:   safe_q <= cfg_data_i;
          REG_SPEED:  minspd_q <= cfg_data_i[14:0];
          REG_RADIUS: radius_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        case (operation_i)
          OP_CLEAR: begin cnt_q <= '0; drop_flag_q <= 1'b0; end
          OP_APPEND: begin
            if (cnt_q < CW'(MAX_TARGETS)) cnt_q <= cnt_q + 1'b1;
            else drop_flag_q <= 1'b1;
          end
          default: ;
        endcase
      end
      if (is_obj) begin
        busy_q <= 1'b1; step_q <= '0; walk_q <= '0;
        hd_done_q <= 1'b0; walk_done_q <= (cnt_q == '0);
      end else if (busy_q) begin
        if (!walk_done_q) begin
          if (walk_q < cnt_q && 42'(d2) <= 42'(r2_q)) near_flag_q <= 1'b1;
          if (walk_q == CW'(MAX_TARGETS - 1)) walk_done_q <= 1'b1;
          walk_q <= walk_q + 1'b1;
        end
        if (!hd_done_q) begin
          if (step_q == ST_LAST) begin
            hd_done_q <= 1'b1;
            if (spd_hit) spd_flag_q <= 1'b1;
          end
          step_q <= step_q + 1'b1;
        end
        if (hd_done_q && walk_done_q) begin
          busy_q <= 1'b0;
          if (last_q) begin
            valid_o <= 1'b1;
            hazard_o <= spd_flag_q || near_flag_q;
            speed_range_hit_o <= spd_flag_q;
            proximity_hit_o <= near_flag_q;
            targets_dropped_o <= drop_flag_q;
            spd_flag_q <= 1'b0; near_flag_q <= 1'b0;
          end
        end
      end
    end
  end
endmodule

[tb/hazard_frame_checker.sv]
module hazard_frame_checker #(
  parameter int MAX_TARGETS  = 32,
  parameter int CORDIC_ITERS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         operation_i,
  input  logic signed [19:0] pos_x_i,
  input  logic signed [19:0] pos_y_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] rel_speed_i,
  input  logic [7:0]         class_label_i,
  input  logic               last_object_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [chc_pkg::CFG_W-1:0] cfg_data_i,
  input  logic               valid_o,
  input  logic               hazard_o,
  input  logic               speed_range_hit_o,
  input  logic               proximity_hit_o,
  input  logic               targets_dropped_o,
  output int                 errors_o,
  output int                 pending_o
);
  import chc_pkg::*;

  localparam logic [7:0] LABEL_LO = 8'd1;
  localparam logic [7:0] LABEL_HI = 8'd3;

  typedef struct packed {
    logic hazard;
    logic speed_hit;
    logic near_hit;
    logic dropped;
  } frame_flags_t;

  frame_flags_t flag_queue[$];
  logic signed [19:0] tgt_x[MAX_TARGETS];
  logic signed [19:0] tgt_y[MAX_TARGETS];
  int unsigned tgt_count;
  logic speed_seen, near_seen, drop_seen;
  logic [18:0] safe_dist;
  logic [14:0] min_spd;
  logic [18:0] radius;

  function automatic void unit_heading(input longint qx, input longint qy,
                                       input longint qz, input longint qw,
                                       output longint hx, output longint hy);
    longint norm, m20, vx, vy, c, s, nvx, nvy, nc, ns;
    logic flip;
    norm = qx * qx + qy * qy + qz * qz + qw * qw;
    m20 = 2 * (qx * qz - qw * qy);
    vx = qw * qw + qx * qx - qy * qy - qz * qz;
    vy = 2 * (qx * qy + qw * qz);
    c = INV_GAIN;
    s = 0;
    flip = 1'b0;
    if (m20 < 0) m20 = -m20;
    if (m20 >= norm) begin
      hx = 65536;
      hy = 0;
      return;
    end
    if (vx < 0) begin
      vx = -vx;
      vy = -vy;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (vy >= 0) begin
        nvx = vx + (vy >>> i);
        nvy = vy - (vx >>> i);
        nc = c - (s >>> i);
        ns = s + (c >>> i);
      end else begin
        nvx = vx - (vy >>> i);
        nvy = vy + (vx >>> i);
        nc = c + (s >>> i);
        ns = s - (c >>> i);
      end
      vx = nvx;
      vy = nvy;
      c = nc;
      s = ns;
    end
    if (flip) begin
      c = -c;
      s = -s;
    end
    hx = c;
    hy = s;
  endfunction

  task automatic predict_transaction();
    longint px, py, spd, hx, hy, ex, ey, dx, dy, lim, r2;
    frame_flags_t res;
    px = pos_x_i;
    py = pos_y_i;
    spd = rel_speed_i;
    case (operation_i)
      OP_CLEAR: begin
        tgt_count = 0;
        drop_seen = 1'b0;
      end
      OP_APPEND: begin
        if (tgt_count < MAX_TARGETS) begin
          tgt_x[tgt_count] = pos_x_i;
          tgt_y[tgt_count] = pos_y_i;
          tgt_count++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      OP_OBJECT: begin
        r2 = longint'(radius) * longint'(radius);
        if (class_label_i >= LABEL_LO && class_label_i <= LABEL_HI) begin
          lim = longint'(safe_dist) * longint'(safe_dist);
          unit_heading(quat_x_i, quat_y_i, quat_z_i, quat_w_i, hx, hy);
          ex = px + ((hx * spd + 32768) >>> 16);
          ey = py + ((hy * spd + 32768) >>> 16);
          if (spd >= longint'(min_spd) && ex * ex + ey * ey <= lim) speed_seen = 1'b1;
        end
        for (int unsigned i = 0; i < tgt_count; i++) begin
          dx = px - longint'(tgt_x[i]);
          dy = py - longint'(tgt_y[i]);
          if (dx * dx + dy * dy <= r2) begin
            near_seen = 1'b1;
            break;
          end
        end
        if (last_object_i) begin
          res.hazard = speed_seen | near_seen;
          res.speed_hit = speed_seen;
          res.near_hit = near_seen;
          res.dropped = drop_seen;
          flag_queue = {flag_queue, res};
          speed_seen = 1'b0;
          near_seen = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_result();
    frame_flags_t exp_flags;
    if (flag_queue.size() == 0) begin
      $error("result with no transaction waiting for one");
      errors_o++;
      return;
    end
    exp_flags = flag_queue.pop_front();
    if (hazard_o !== exp_flags.hazard) begin
      $error("hazard: expected %0b, actual %0b", exp_flags.hazard, hazard_o);
      errors_o++;
    end
    if (speed_range_hit_o !== exp_flags.speed_hit) begin
      $error("speed_range_hit: expected %0b, actual %0b", exp_flags.speed_hit,
             speed_range_hit_o);
      errors_o++;
    end
    if (proximity_hit_o !== exp_flags.near_hit) begin
      $error("proximity_hit: expected %0b, actual %0b", exp_flags.near_hit, proximity_hit_o);
      errors_o++;
    end
    if (targets_dropped_o !== exp_flags.dropped) begin
      $error("targets_dropped: expected %0b, actual %0b", exp_flags.dropped,
             targets_dropped_o);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_count = 0;
      speed_seen = 1'b0;
      near_seen = 1'b0;
      drop_seen = 1'b0;
      safe_dist = 19'd5120;
      min_spd = 15'd1423;
      radius = 19'd384;
      flag_queue.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (valid_o === 1'b1) compare_result();
      if (start && busy === 1'b0) predict_transaction();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SAFE: safe_dist = cfg_data_i[18:0];
          REG_SPEED: min_spd = cfg_data_i[14:0];
          REG_RADIUS: radius = cfg_data_i[18:0];
          default: ;
        endcase
      end
      pending_o = flag_queue.size();
    end
  end

endmodule

[tb/collision_hazard_check_test.sv]
module collision_hazard_check_test;
  import chc_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int NUM_ITEMS = 1400;
  localparam int QUIET_TAIL = 150;
  localparam int DRAIN_CYCLES = 60;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         operation_i = OP_CLEAR;
  logic signed [19:0] pos_x_i = '0;
  logic signed [19:0] pos_y_i = '0;
  logic signed [15:0] quat_x_i = '0;
  logic signed [15:0] quat_y_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic signed [15:0] quat_w_i = '0;
  logic signed [15:0] rel_speed_i = '0;
  logic [7:0]         class_label_i = '0;
  logic               last_object_i = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = REG_SAFE;
  logic [CFG_W-1:0]   cfg_data_i = '0;
  logic               valid_o;
  logic               hazard_o;
  logic               speed_range_hit_o;
  logic               proximity_hit_o;
  logic               targets_dropped_o;
  int                 errors;
  int                 pending;

  int item_count = 0;
  logic quiet = 1'b0;
  logic signed [19:0] path_x[$];
  logic signed [19:0] path_y[$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  collision_hazard_check uut (.*);

  hazard_frame_checker checker_i (.errors_o(errors), .pending_o(pending), .*);

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send(input logic [1:0] op, input logic signed [19:0] x,
                      input logic signed [19:0] y, input logic signed [15:0] qx,
                      input logic signed [15:0] qy, input logic signed [15:0] qz,
                      input logic signed [15:0] qw, input logic signed [15:0] spd,
                      input logic [7:0] lbl, input logic last);
    logic was_busy;
    @(negedge clk_i);
    operation_i = op;
    pos_x_i = x;
    pos_y_i = y;
    quat_x_i = qx;
    quat_y_i = qy;
    quat_z_i = qz;
    quat_w_i = qw;
    rel_speed_i = spd;
    class_label_i = lbl;
    last_object_i = last;
    start = 1'b1;
    forever begin
      was_busy = busy;
      @(posedge clk_i);
      if (!was_busy) break;
      @(negedge clk_i);
    end
    item_count++;
    if (op == OP_APPEND && path_x.size() < 64) begin
      path_x = {path_x, x};
      path_y = {path_y, y};
    end
    if (op == OP_CLEAR) begin
      path_x.delete();
      path_y.delete();
    end
    if (!quiet && $urandom_range(3) == 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    start = 1'b0;
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(input logic [18:0] sd, input logic [14:0] ms, input logic [18:0] pr);
    wait_idle();
    write_reg(REG_SAFE, sd);
    write_reg(REG_SPEED, 19'(ms));
    write_reg(REG_RADIUS, pr);
  endtask

  task automatic send_object(input logic signed [19:0] x, input logic signed [19:0] y,
                             input logic last);
    logic signed [15:0] q[4];
    logic signed [15:0] spd;
    logic [7:0] lbl;
    case ($urandom_range(5))
      0: q = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
      1: q = '{16'sd0, 16'sd11585, 16'sd0, 16'sd11585};
      2: q = '{16'sd0, 16'sd0, 16'($urandom_range(32767)), 16'($urandom_range(32767))};
      default: q = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    endcase
    case ($urandom_range(3))
      0: spd = 16'($urandom);
      1: spd = -16'sd1 - 16'($urandom_range(2000));
      default: spd = 16'($urandom_range(4000));
    endcase
    case ($urandom_range(5))
      0: lbl = 8'($urandom);
      1: lbl = 8'd0;
      default: lbl = 8'($urandom_range(3, 1));
    endcase
    send(OP_OBJECT, x, y, q[0], q[1], q[2], q[3], spd, lbl, last);
  endtask

  task automatic random_object(input logic last);
    logic signed [19:0] x, y;
    int k;
    case ($urandom_range(4))
      0: begin
        x = 20'($urandom);
        y = 20'($urandom);
      end
      1: begin
        if (path_x.size() > 0) begin
          k = $urandom_range(path_x.size() - 1);
          x = path_x[k] + 20'($signed(12'($urandom)));
          y = path_y[k] + 20'($signed(12'($urandom)));
        end else begin
          x = 20'($signed(12'($urandom)));
          y = 20'($signed(12'($urandom)));
        end
      end
      default: begin
        x = 20'($signed(14'($urandom)));
        y = 20'($signed(14'($urandom)));
      end
    endcase
    send_object(x, y, last);
  endtask

  task automatic random_phase(input int count);
    int target;
    int n;
    target = item_count + count;
    while (item_count < target) begin
      quiet = (item_count >= NUM_ITEMS - QUIET_TAIL);
      case ($urandom_range(9))
        0: send(OP_CLEAR, 20'($urandom), 20'($urandom), '0, '0, '0, '0, '0, '0,
                1'($urandom));
        1: begin
          n = $urandom_range(20, 1);
          repeat (n) begin
            if ($urandom_range(1))
              send(OP_APPEND, 20'($signed(14'($urandom))), 20'($signed(14'($urandom))),
                   '0, '0, '0, '0, '0, '0, 1'($urandom));
            else
              send(OP_APPEND, 20'($urandom), 20'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                   1'($urandom));
          end
        end
        2: send(OP_NONE, 20'($urandom), 20'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                1'($urandom));
        default: begin
          n = $urandom_range(6, 1);
          for (int i = 0; i < n; i++) random_object(i == n - 1);
        end
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at reset settings.
    send(OP_OBJECT, 20'sd0, 20'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd2000, 8'd1, 1'b1);
    send(OP_APPEND, -20'sd524288, 20'sd524287, '0, '0, '0, '0, '0, '0, 1'b1);
    send(OP_APPEND, 20'sd100, -20'sd100, '0, '0, '0, '0, '0, '0, 1'b0);
    send(OP_OBJECT, 20'sd120, -20'sd90, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1423, 8'd2,
         1'b1);
    send(OP_OBJECT, 20'sd524287, -20'sd524288, 16'sd0, 16'sd11585, 16'sd0, 16'sd11585,
         16'sd32767, 8'd3, 1'b1);
    send(OP_OBJECT, -20'sd1000, 20'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd1422, 8'd1,
         1'b1);
    send(OP_OBJECT, -20'sd1000, 20'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, -16'sd32768,
         8'd1, 1'b0);
    send(OP_OBJECT, -20'sd524288, 20'sd524287, -16'sd32768, 16'sd32767, -16'sd32768,
         16'sd32767, 16'sd32767, 8'd255, 1'b0);
    send(OP_OBJECT, 20'sd100, -20'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 8'd0,
         1'b0);
    send(OP_OBJECT, 20'sd0, 20'sd0, 16'sd0, 16'sd0, 16'sd11585, -16'sd11585, 16'sd5000,
         8'd4, 1'b1);
    send(OP_NONE, 20'sd0, 20'sd0, '0, '0, '0, '0, '0, '0, 1'b1);
    send(OP_CLEAR, 20'sd0, 20'sd0, '0, '0, '0, '0, '0, '0, 1'b1);
    send(OP_OBJECT, 20'sd100, -20'sd100, 16'sd100, -16'sd200, 16'sd300, -16'sd400,
         16'sd3000, 8'd1, 1'b1);

    random_phase(260);
    configure(19'h7FFFF, 15'h7FFF, 19'h7FFFF);
    random_phase(260);
    configure(19'd0, 15'd0, 19'd0);
    random_phase(260);
    configure(19'd8000, 15'd500, 19'd2000);
    random_phase(260);
    configure(19'($urandom), 15'($urandom_range(3000)), 19'($urandom_range(8000)));
    random_phase(NUM_ITEMS - item_count);

    wait_idle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
